FILE: hdl/program_stream_header_length_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the program stream header length block
// Same-cycle-implication and next-cycle-implication checks, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_HEADER_LENGTH_TOP_DEFINES_SVH
`define PROGRAM_STREAM_HEADER_LENGTH_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psh assertion failed");
// next-cycle implication
`define PSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psh assertion failed");
`else
`define PSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Types and constants of the program stream header length block.
// ----------------------------------------------------------------------------
package psh_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_ID = 1'd1;

  localparam logic [BYTE_W-1:0] VIDEO_ID_RST = 8'hE0;
  localparam logic [BYTE_W-1:0] AUDIO_ID_RST = 8'hC0;

  // start code type bytes
  localparam logic [BYTE_W-1:0] SC_PACK     = 8'hBA;
  localparam logic [BYTE_W-1:0] SC_SYSTEM   = 8'hBB;
  localparam logic [BYTE_W-1:0] SC_STREAM_MAP = 8'hBC;
  localparam logic [BYTE_W-1:0] SC_END      = 8'hB9;

  // fixed-field byte positions
  localparam logic [IDX_W-1:0] FIRST_FIELD_IDX = 4'd4;
  localparam logic [IDX_W-1:0] PACK_STUFF_IDX  = 4'd13;
  localparam logic [IDX_W-1:0] PES_LEN_IDX     = 4'd8;
  localparam logic [2:0]       PACK_STUFF_MASK = 3'h7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_FIELDS,
    PH_SKIP,
    PH_DONE
  } psh_phase_t;

  typedef enum logic [1:0] {
    KIND_PACK,
    KIND_SYS,
    KIND_PES
  } psh_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]    head_len;
    logic [STATUS_W-1:0] status;
  } psh_result_t;

endpackage

FILE: hdl/psh_in_if.sv
// ----------------------------------------------------------------------------
// psh_in_if
// Byte input channel: valid/ready handshake with byte and end-of-payload flag.
// ----------------------------------------------------------------------------
interface psh_in_if;
  import psh_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/psh_out_if.sv
// ----------------------------------------------------------------------------
// psh_out_if
// Result channel: valid/ready handshake with header length and status.
// ----------------------------------------------------------------------------
interface psh_out_if;
  import psh_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEN_W-1:0]    head_len;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output head_len, output status, input ready);
  modport sink   (input valid, input head_len, input status, output ready);
endinterface

FILE: hdl/program_stream_header_length_top.sv
// A byte is accepted into the input register and steps the parser from there; its result
// word is loaded into the result register when that parse step is taken.
// Throughput: one byte per cycle unless stalled; the single-pass parse step sets it.
// A byte stalls in the input register only while the result register is full and unread.
// Reset (rst_n low, synchronous): parse state cleared, stream ids back to E0 and C0.
// ----------------------------------------------------------------------------
// program_stream_header_length_top
// Finds the first video/audio packet header in a program stream payload and
// reports the header length, or that the header is truncated or absent.
// ----------------------------------------------------------------------------
module program_stream_header_length_top (
  input  logic                          clk,
  input  logic                          rst_n,
  psh_in_if.sink                        in_s,
  psh_out_if.source                     out_s,
  input  logic                          cfg_we,
  input  logic [psh_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [psh_pkg::BYTE_W-1:0]    cfg_wdata
);
  import psh_pkg::*;

  logic [BYTE_W-1:0] video_id_r;
  logic [BYTE_W-1:0] audio_id_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              in_ready;
  logic              out_valid_r;
  psh_result_t       out_r;
  logic              res_valid;
  psh_result_t       res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_id_r <= VIDEO_ID_RST;
      audio_id_r <= AUDIO_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VIDEO_ID: video_id_r <= cfg_wdata;
        CFG_AUDIO_ID: audio_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance the input word when the result slot is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_s.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_s.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_s.valid) begin
      s1_byte_r <= in_s.data_byte;
      s1_last_r <= in_s.last_byte;
    end
  end

  psh_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .video_id  (video_id_r),
    .audio_id  (audio_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_s.valid    = out_valid_r;
  assign out_s.head_len = out_r.head_len;
  assign out_s.status   = out_r.status;

`include "program_stream_header_length_top_defines.svh"

  `PSH_ASSERT_IMPLY(a_len_zero_on_fail, clk, rst_n,
                    out_valid_r && out_r.status != ST_FOUND, out_r.head_len == '0)
  `PSH_ASSERT_IMPLY(a_stall_only_full, clk, rst_n, !in_ready,
                    s1_valid_r && out_valid_r && !out_s.ready)
  `PSH_ASSERT_NEXT(a_result_loaded, clk, rst_n, res_valid, out_valid_r)

endmodule

FILE: hdl/psh_parser.sv
// ----------------------------------------------------------------------------
// psh_parser
// Per-byte parse state and the one-step update: start code hunt, header skip,
// packet header length report.
// ----------------------------------------------------------------------------
module psh_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [psh_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        last_byte,
  input  logic [psh_pkg::BYTE_W-1:0]  video_id,
  input  logic [psh_pkg::BYTE_W-1:0]  audio_id,
  output logic                        res_valid,
  output psh_pkg::psh_result_t        res
);
  import psh_pkg::*;

  psh_phase_t       phase_r, phase_nxt;
  psh_kind_t        kind_r, kind_nxt;
  logic [1:0]       zrun_r, zrun_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] skip_r, skip_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] pos_inc;
  logic             hdr_end;
  logic             end_fixed;
  logic             found;
  logic [LEN_W-1:0] skip_dec;

  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 16'd1;
  assign skip_dec = (skip_r != '0) ? skip_r - 16'd1 : skip_r;

  // one parse step on the current byte
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    zrun_nxt  = zrun_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    hdr_end   = 1'b0;
    end_fixed = 1'b0;
    found     = 1'b0;
    res_valid = 1'b0;
    res       = '{head_len: '0, status: ST_NONE};

    unique case (phase_r)
      PH_HUNT: begin
        if (data_byte == 8'h00) begin
          if (zrun_r != 2'd2) zrun_nxt = zrun_r + 2'd1;
        end else if (data_byte == 8'h01 && zrun_r == 2'd2) begin
          phase_nxt = PH_TYPE;
          zrun_nxt  = 2'd0;
        end else begin
          zrun_nxt = 2'd0;
        end
      end
      PH_TYPE: begin
        idx_nxt  = FIRST_FIELD_IDX;
        skip_nxt = '0;
        priority if (data_byte == SC_PACK) begin
          kind_nxt  = KIND_PACK;
          phase_nxt = PH_FIELDS;
        end else if (data_byte == SC_SYSTEM || data_byte == SC_STREAM_MAP) begin
          kind_nxt  = KIND_SYS;
          phase_nxt = PH_FIELDS;
        end else if (data_byte == SC_END) begin
          phase_nxt = PH_HUNT;
          zrun_nxt  = 2'd0;
        end else if (data_byte == video_id || data_byte == audio_id) begin
          kind_nxt  = KIND_PES;
          phase_nxt = PH_FIELDS;
        end else begin
          // unknown code: resync, a zero may open the next start code
          phase_nxt = PH_HUNT;
          zrun_nxt  = (data_byte == 8'h00) ? 2'd1 : 2'd0;
        end
      end
      PH_FIELDS: begin
        unique case (kind_r)
          KIND_PACK: begin
            if (idx_r >= PACK_STUFF_IDX) begin
              skip_nxt  = {13'd0, data_byte[2:0] & PACK_STUFF_MASK};
              end_fixed = 1'b1;
            end
          end
          KIND_SYS: begin
            if (idx_r == FIRST_FIELD_IDX) begin
              skip_nxt = {data_byte, 8'h00};
            end else begin
              skip_nxt  = {skip_r[15:8], data_byte};
              end_fixed = 1'b1;
            end
          end
          KIND_PES: begin
            if (idx_r >= PES_LEN_IDX) begin
              skip_nxt  = {8'h00, data_byte};
              end_fixed = 1'b1;
            end
          end
          default: ;
        endcase
        if (end_fixed) begin
          if (skip_nxt == '0) hdr_end = 1'b1;
          else phase_nxt = PH_SKIP;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) hdr_end = 1'b1;
      end
      PH_DONE: ;
      default: ;
    endcase

    // header finished: packet headers report, others resume hunting
    if (hdr_end) begin
      phase_nxt = PH_HUNT;
      zrun_nxt  = 2'd0;
      found     = (kind_r == KIND_PES);
    end

    if (found) begin
      res_valid = 1'b1;
      res       = '{head_len: pos_inc, status: ST_FOUND};
      phase_nxt = PH_DONE;
    end else if (last_byte && phase_r != PH_DONE) begin
      res_valid = 1'b1;
      res.status = (phase_nxt == PH_FIELDS || phase_nxt == PH_SKIP) ? ST_TRUNC : ST_NONE;
    end

    // end of payload clears everything; else advance the position
    if (last_byte) begin
      phase_nxt = PH_HUNT;
      kind_nxt  = KIND_PACK;
      zrun_nxt  = 2'd0;
      idx_nxt   = '0;
      skip_nxt  = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = pos_inc;
    end

    if (!step_en) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= KIND_PACK;
      zrun_r  <= 2'd0;
      idx_r   <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      zrun_r  <= zrun_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
    end
  end

`include "program_stream_header_length_top_defines.svh"

  `PSH_ASSERT_NEXT(a_last_clears, clk, rst_n, step_en && last_byte,
                   phase_r == PH_HUNT && pos_r == '0)
  `PSH_ASSERT_IMPLY(a_skip_nonzero, clk, rst_n, phase_r == PH_SKIP, skip_r != '0)

endmodule

FILE: bench/program_stream_header_length_top_tb.sv
// ----------------------------------------------------------------------------
// program_stream_header_length_top_tb
// Streams program stream payloads into the header length finder one byte word
// at a time and checks every result word against the directed table's expected result or a cycle-free parse model.
// A directed table comes first, then random payloads built from pack, system,
// stream map, end and packet headers under several stream id settings.
// ----------------------------------------------------------------------------
module program_stream_header_length_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psh_pkg::*;

  localparam logic [BYTE_W-1:0] SC_PREFIX_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SC_PREFIX_ONE  = 8'h01;
  localparam psh_result_t       NO_RES         = '0;
  localparam int DIR_N          = 32;
  localparam int N_PHASES       = 8;
  localparam int PHASE_BYTES    = 250;
  localparam int MAX_SHOWN      = 10;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_LIMIT    = 20000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                typed;
    psh_result_t       res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_wdata;

  psh_in_if  in_bus ();
  psh_out_if out_bus ();

  program_stream_header_length_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_bus),
    .out_s     (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parse model state and stream id copies
  psh_phase_t        sc_phase;
  logic [1:0]        sc_zeros;
  psh_kind_t         sc_kind;
  logic [IDX_W-1:0]  sc_field;
  logic [16:0]       sc_skip;
  logic [LEN_W-1:0]  sc_pos;
  logic              sc_reported;
  logic [BYTE_W-1:0] video_id;
  logic [BYTE_W-1:0] audio_id;

  psh_result_t       header_len_q[$];
  logic [BYTE_W-1:0] pay_q[$];
  dir_row_t          dir_rows [DIR_N];
  int                err_count = 0;
  int                burst_left = 0;
  bit                gaps_on = 1'b1;

  function automatic void flag_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // return the parse to a fresh payload
  function automatic void clear_scan_state();
    sc_phase    = PH_HUNT;
    sc_zeros    = '0;
    sc_kind     = KIND_PACK;
    sc_field    = '0;
    sc_skip     = '0;
    sc_pos      = '0;
    sc_reported = 1'b0;
  endfunction

  // close a header: only a packet header counts as found
  function automatic bit close_header();
    sc_phase = PH_HUNT;
    sc_zeros = '0;
    return sc_kind == KIND_PES;
  endfunction

  // advance the parse by one byte word; return 1 when it yields a result word
  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                   output psh_result_t res);
    bit hit;
    bit fixed_end;
    bit emit;
    hit       = 1'b0;
    fixed_end = 1'b0;
    emit      = 1'b0;
    res       = NO_RES;
    case (sc_phase)
      PH_HUNT: begin
        if (b == SC_PREFIX_ZERO) begin
          if (sc_zeros < 2'd2) sc_zeros = sc_zeros + 2'd1;
        end else if (b == SC_PREFIX_ONE && sc_zeros >= 2'd2) begin
          sc_phase = PH_TYPE;
          sc_zeros = '0;
        end else begin
          sc_zeros = '0;
        end
      end
      PH_TYPE: begin
        sc_field = FIRST_FIELD_IDX;
        sc_skip  = '0;
        // fixed codes take precedence over the stream id registers
        if (b == SC_PACK) begin
          sc_kind  = KIND_PACK;
          sc_phase = PH_FIELDS;
        end else if (b == SC_SYSTEM || b == SC_STREAM_MAP) begin
          sc_kind  = KIND_SYS;
          sc_phase = PH_FIELDS;
        end else if (b == SC_END) begin
          sc_phase = PH_HUNT;
          sc_zeros = '0;
        end else if (b == video_id || b == audio_id) begin
          sc_kind  = KIND_PES;
          sc_phase = PH_FIELDS;
        end else begin
          // unknown type: a zero byte already starts the next prefix
          sc_phase = PH_HUNT;
          sc_zeros = (b == SC_PREFIX_ZERO) ? 2'd1 : 2'd0;
        end
      end
      PH_FIELDS: begin
        case (sc_kind)
          KIND_PACK: begin
            if (sc_field >= PACK_STUFF_IDX) begin
              sc_skip   = {14'd0, b[2:0] & PACK_STUFF_MASK};
              fixed_end = 1'b1;
            end
          end
          KIND_SYS: begin
            if (sc_field == FIRST_FIELD_IDX) begin
              sc_skip = {1'b0, b, 8'h00};
            end else begin
              sc_skip   = {1'b0, sc_skip[15:8], b};
              fixed_end = 1'b1;
            end
          end
          default: begin
            if (sc_field >= PES_LEN_IDX) begin
              sc_skip   = {9'd0, b};
              fixed_end = 1'b1;
            end
          end
        endcase
        if (fixed_end) begin
          if (sc_skip == '0) hit = close_header();
          else sc_phase = PH_SKIP;
        end else begin
          sc_field = sc_field + 1'b1;
        end
      end
      PH_SKIP: begin
        if (sc_skip != '0) sc_skip = sc_skip - 1'b1;
        if (sc_skip == '0) hit = close_header();
      end
      default: ;
    endcase

    if (hit && !sc_reported) begin
      res.head_len = (sc_pos == '1) ? '1 : sc_pos + 1'b1;
      res.status   = ST_FOUND;
      emit         = 1'b1;
      sc_reported  = 1'b1;
      sc_phase     = PH_DONE;
    end else if (last && !sc_reported) begin
      res.head_len = '0;
      res.status   = (sc_phase == PH_FIELDS || sc_phase == PH_SKIP) ? ST_TRUNC : ST_NONE;
      emit         = 1'b1;
    end

    if (last) clear_scan_state();
    else if (sc_pos != '1) sc_pos = sc_pos + 1'b1;
    return emit;
  endfunction

  // send one byte word in bursts, with random gaps while gaps_on is set; record the expected result
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input bit typed, input psh_result_t typed_res);
    psh_result_t res;
    bit          emit;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    emit = scan_byte(b, last, res);
    if (typed) header_len_q.push_back(typed_res);
    else if (emit) header_len_q.push_back(res);
  endtask

  // hold off input until every result word is back and the pipe is empty
  task automatic wait_results_drained();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    while (header_len_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_stream_ids(input logic [BYTE_W-1:0] v, input logic [BYTE_W-1:0] a);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_VIDEO_ID;
    cfg_wdata <= v;
    @(posedge clk);
    video_id = v;
    cfg_idx   <= CFG_AUDIO_ID;
    cfg_wdata <= a;
    @(posedge clk);
    audio_id = a;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 3))
      0, 1:    return SC_PREFIX_ZERO;
      2:       return SC_PREFIX_ONE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_start(input logic [BYTE_W-1:0] kind_byte);
    pay_q.push_back(SC_PREFIX_ZERO);
    pay_q.push_back(SC_PREFIX_ZERO);
    pay_q.push_back(SC_PREFIX_ONE);
    pay_q.push_back(kind_byte);
  endfunction

  function automatic void add_random(input int n);
    repeat (n) pay_q.push_back(BYTE_W'($urandom_range(0, 255)));
  endfunction

  // headers that the block passes over
  function automatic void add_skipped_header();
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic [2:0]        stuff;
    case ($urandom_range(0, 4))
      0: begin
        add_start(SC_PACK);
        add_random(9);
        stuff = 3'($urandom_range(0, 7));
        pay_q.push_back({5'($urandom_range(0, 31)), stuff});
        add_random(stuff);
      end
      1, 2: begin
        add_start($urandom_range(0, 1) ? SC_SYSTEM : SC_STREAM_MAP);
        hi = ($urandom_range(0, 15) == 0) ? 8'h01 : 8'h00;
        lo = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255))
                                         : BYTE_W'($urandom_range(0, 15));
        pay_q.push_back(hi);
        pay_q.push_back(lo);
        add_random({hi, lo});
      end
      3: add_start(SC_END);
      default: add_start(BYTE_W'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void add_packet_header(input logic [BYTE_W-1:0] id);
    logic [BYTE_W-1:0] hl;
    add_start(id);
    add_random(4);
    hl = ($urandom_range(0, 15) == 0) ? BYTE_W'($urandom_range(0, 255))
                                      : BYTE_W'($urandom_range(0, 12));
    pay_q.push_back(hl);
    add_random(hl);
  endfunction

  // mostly well-formed payloads with random content; some noise, some cut short
  function automatic void build_payload();
    int cut;
    pay_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) pay_q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 2)) pay_q.push_back(noise_byte());
      repeat ($urandom_range(0, 3)) add_skipped_header();
      if ($urandom_range(0, 7) != 0)
        add_packet_header($urandom_range(0, 1) ? video_id : audio_id);
      add_random($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0 && pay_q.size() > 1) begin
        cut   = $urandom_range(0, pay_q.size() - 1);
        pay_q = pay_q[0:cut];
      end
    end
    if (pay_q.size() == 0) pay_q.push_back(noise_byte());
  endfunction

  task automatic send_payload();
    for (int i = 0; i < pay_q.size(); i++)
      push_byte(pay_q[i], i == pay_q.size() - 1, 1'b0, NO_RES);
  endtask

  // receiver: stall pattern is redrawn each time the 8-bit rx_tick wraps to zero
  logic [7:0] rx_tick = '0;
  rx_mode_t   rx_mode = RX_OPEN;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_bus.ready <= 1'b1;
      RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
      default:   out_bus.ready <= rx_tick[4];
    endcase
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    psh_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (header_len_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result head_len=%0d status=%0d",
                                out_bus.head_len, out_bus.status));
      end else begin
        want = header_len_q.pop_front();
        if (out_bus.head_len !== want.head_len)
          flag_mismatch($sformatf("head_len expected %0d got %0d",
                                  want.head_len, out_bus.head_len));
        if (out_bus.status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d",
                                  want.status, out_bus.status));
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] a;
    int                sent;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_VIDEO_ID;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;
    video_id         = VIDEO_ID_RST;
    audio_id         = AUDIO_ID_RST;
    clear_scan_state();

    dir_rows = '{
      // payload ends while hunting
      '{SC_PREFIX_ZERO, 1'b1, 1'b1, '{16'd0, ST_NONE}},
      // payload ends right after a start code
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b1, 1'b1, '{16'd0, ST_NONE}},
      // zero type byte restarts the prefix, then end code, system header of
      // one byte, audio header at offset 14, and a byte after the report
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b0, 1'b0, NO_RES},
      '{SC_END,         1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b0, 1'b0, NO_RES},
      '{SC_SYSTEM,      1'b0, 1'b0, NO_RES},
      '{8'h00,          1'b0, 1'b0, NO_RES},
      '{8'h01,          1'b0, 1'b0, NO_RES},
      '{8'hFF,          1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b0, 1'b0, NO_RES},
      '{AUDIO_ID_RST,   1'b0, 1'b0, NO_RES},
      '{8'hFF,          1'b0, 1'b0, NO_RES},
      '{8'hFF,          1'b0, 1'b0, NO_RES},
      '{8'hFF,          1'b0, 1'b0, NO_RES},
      '{8'hFF,          1'b0, 1'b0, NO_RES},
      '{8'h00,          1'b0, 1'b1, '{16'd23, ST_FOUND}},
      '{8'h01,          1'b1, 1'b0, NO_RES},
      // payload ends on a stream map type byte
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ZERO, 1'b0, 1'b0, NO_RES},
      '{SC_PREFIX_ONE,  1'b0, 1'b0, NO_RES},
      '{SC_STREAM_MAP,  1'b1, 1'b1, '{16'd0, ST_TRUNC}}
    };

    // hold reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

    // random payloads, one stream id setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_results_drained();
      case (ph)
        0: begin v = VIDEO_ID_RST;  a = AUDIO_ID_RST;  end
        1: begin v = 8'h00;         a = 8'hFF;         end
        2: begin v = 8'hFF;         a = 8'h00;         end
        3: begin v = SC_PACK;       a = SC_END;        end
        4: begin v = SC_SYSTEM;     a = SC_STREAM_MAP; end
        5: begin v = 8'h55;         a = 8'h55;         end
        6: begin
          v = BYTE_W'($urandom_range(0, 255));
          a = BYTE_W'($urandom_range(0, 255));
        end
        default: begin v = VIDEO_ID_RST; a = AUDIO_ID_RST; end
      endcase
      load_stream_ids(v, a);
      gaps_on    = (ph % 3 != 2);
      burst_left = 0;
      sent       = 0;
      while (sent < PHASE_BYTES) begin
        build_payload();
        send_payload();
        sent += pay_q.size();
      end
    end

    wait_results_drained();
    if (header_len_q.size() != 0)
      flag_mismatch($sformatf("%0d result words never arrived", header_len_q.size()));
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // drop the run if it hangs
  initial begin
    #2_000_000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
